[rtl/capacitive_touch_key_detector_macros.svh]
// Assertion macros shared by the capacitive touch key detector RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef CAPACITIVE_TOUCH_KEY_DETECTOR_MACROS_SVH
`define CAPACITIVE_TOUCH_KEY_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTKD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("capacitive_touch_key_detector: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CTKD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("capacitive_touch_key_detector: assertion failed");

`endif

[rtl/ctkd_pkg.sv]
// Shared types and constants for the capacitive touch key detector.
// No dependencies.
package ctkd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int MINV_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int LO_W      = 17;
  localparam int HI_W      = 20;

  localparam logic [SAMPLE_W-1:0] CAPTURE_LOW_RST  = 16'd50;
  localparam logic [SAMPLE_W-1:0] CAPTURE_HIGH_RST = 16'd2500;
  localparam logic [MINV_W-1:0]   MIN_VALID_RST    = 3'd2;

  // Reciprocal of 3 for an exact floor division of an 18-bit value.
  localparam logic [18:0] LO_MULT  = 19'd349526;
  localparam int          LO_SHIFT = 20;

  localparam logic KIND_CALIB = 1'b0;
  localparam logic KIND_SCAN  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPTURE_LOW  = 2'd0,
    CFG_CAPTURE_HIGH = 2'd1,
    CFG_MIN_VALID    = 2'd2
  } ctkd_cfg_idx_t;

  typedef struct packed {
    logic calibrating;
    logic pending;
    logic done;
  } ctkd_cal_stat_t;

endpackage

[rtl/ctkd_calib.sv]
// Baseline calibration: running sum, two smallest samples, division and press window.
// Depends on ctkd_pkg.
module ctkd_calib #(
  parameter int CALIB_SAMPLES = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           take,
  input  logic [ctkd_pkg::SAMPLE_W-1:0]  sample,
  input  logic                           emit_ack,
  output ctkd_pkg::ctkd_cal_stat_t       stat,
  output logic [ctkd_pkg::SAMPLE_W-1:0]  baseline,
  output logic [ctkd_pkg::LO_W-1:0]      lo,
  output logic [ctkd_pkg::HI_W-1:0]      hi
);
  import ctkd_pkg::*;

  localparam int CNT_W  = $clog2(CALIB_SAMPLES);
  localparam int SUM_W  = SAMPLE_W + $clog2(CALIB_SAMPLES);
  localparam int DIV    = CALIB_SAMPLES - 2;
  localparam int DIV_SH = SUM_W + 4;
  localparam int MULT_W = DIV_SH + 1;
  localparam logic [63:0] DIV_MULT_L = ((64'd1 << DIV_SH) + DIV - 1) / DIV;
  localparam logic [MULT_W-1:0] DIV_MULT = DIV_MULT_L[MULT_W-1:0];
  localparam int PROD_W = SUM_W + MULT_W;

  typedef enum logic [2:0] {
    ST_CAL, ST_KEPT, ST_DIV, ST_THR, ST_EMIT, ST_SCAN
  } cal_state_t;

  cal_state_t          state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] small1_r;
  logic [SAMPLE_W-1:0] small2_r;
  logic [SUM_W-1:0]    kept_r;
  logic [SAMPLE_W-1:0] baseline_r;
  logic [LO_W-1:0]     lo_r;
  logic [HI_W-1:0]     hi_r;
  logic [PROD_W-1:0]   div_prod;
  logic [36:0]         lo_prod;

  assign div_prod = {{MULT_W{1'b0}}, kept_r} * {{SUM_W{1'b0}}, DIV_MULT};
  assign lo_prod  = {19'd0, baseline_r, 2'b00} * {18'd0, LO_MULT};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CAL;
      cnt_r      <= '0;
      sum_r      <= '0;
      small1_r   <= '1;
      small2_r   <= '1;
      kept_r     <= '0;
      baseline_r <= '0;
      lo_r       <= '0;
      hi_r       <= '0;
    end else begin
      case (state_r)
        ST_CAL: begin
          if (take) begin
            sum_r <= sum_r + SUM_W'(sample);
            if (sample < small1_r) begin
              small2_r <= small1_r;
              small1_r <= sample;
            end else if (sample < small2_r) begin
              small2_r <= sample;
            end
            if (cnt_r == CNT_W'(CALIB_SAMPLES - 1)) begin
              cnt_r   <= '0;
              state_r <= ST_KEPT;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        ST_KEPT: begin
          kept_r  <= sum_r - SUM_W'(small1_r) - SUM_W'(small2_r);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          baseline_r <= div_prod[DIV_SH +: SAMPLE_W];
          state_r    <= ST_THR;
        end
        ST_THR: begin
          lo_r    <= lo_prod[LO_SHIFT +: LO_W];
          hi_r    <= {1'b0, baseline_r, 3'b000} + {3'b000, baseline_r, 1'b0};
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_ack) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          state_r <= ST_SCAN;
        end
        default: begin
          state_r <= ST_CAL;
        end
      endcase
    end
  end

  assign stat.calibrating = (state_r == ST_CAL);
  assign stat.pending     = (state_r == ST_EMIT);
  assign stat.done        = (state_r == ST_SCAN);
  assign baseline         = baseline_r;
  assign lo               = lo_r;
  assign hi               = hi_r;

endmodule

[rtl/capacitive_touch_key_detector.sv]
// Top level of the capacitive touch key detector: configuration, scan groups, result register.
// Depends on ctkd_pkg, ctkd_calib and capacitive_touch_key_detector_macros.svh.
//
// Usage: charge-time captures enter on the in_ channel (valid/ready), one per transaction.
// The first CALIB_SAMPLES transactions calibrate the baseline; the baseline is the mean of
// all but the two smallest of them. After the last calibration sample the calibrator steps
// through ST_KEPT, ST_DIV and ST_THR to ST_EMIT, where one kind 0 transaction carries the
// baseline on the out_ channel. Until it is loaded, in_ready is low. From then on every
// SCAN_SAMPLES inputs give one kind 1 transaction with the qualified group maximum and the
// press flag. A scan result is registered in the cycle its last sample is accepted, so it
// appears in the following cycle; one sample is accepted per cycle while in_ready is high.
// The result register is free again in the cycle out_ready takes it, so a stalled receiver
// holds back only the sample that closes a group. Configuration writes through cfg_we,
// cfg_index and cfg_wdata take effect at once; the user must make them only while the
// block is idle, which the block does not enforce. Synchronous reset restores the register
// defaults and restarts calibration.
`include "capacitive_touch_key_detector_macros.svh"

module capacitive_touch_key_detector #(
  parameter int CALIB_SAMPLES = 10,
  parameter int SCAN_SAMPLES  = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ctkd_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [ctkd_pkg::SAMPLE_W-1:0]   out_level,
  output logic                            out_pressed,
  input  logic                            cfg_we,
  input  logic [ctkd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctkd_pkg::SAMPLE_W-1:0]   cfg_wdata
);
  import ctkd_pkg::*;

  localparam int GC_W = (SCAN_SAMPLES > 1) ? $clog2(SCAN_SAMPLES) : 1;
  localparam int VC_W = $clog2(SCAN_SAMPLES + 1);

  ctkd_cal_stat_t      stat;
  logic [SAMPLE_W-1:0] baseline;
  logic [LO_W-1:0]     lo;
  logic [HI_W-1:0]     hi;

  logic [SAMPLE_W-1:0] cap_low_r;
  logic [SAMPLE_W-1:0] cap_high_r;
  logic [MINV_W-1:0]   min_valid_r;
  logic [GC_W-1:0]     grp_cnt_r;
  logic [SAMPLE_W-1:0] grp_max_r;
  logic [VC_W-1:0]     vld_cnt_r;
  logic                out_valid_r;
  logic                out_kind_r;
  logic [SAMPLE_W-1:0] out_level_r;
  logic                out_pressed_r;

  logic                grp_last;
  logic                out_free;
  logic                in_ready_w;
  logic                take;
  logic                cal_take;
  logic                scan_take;
  logic                emit_ack;
  logic                in_win;
  logic [SAMPLE_W-1:0] max_nxt;
  logic [VC_W-1:0]     vc_nxt;
  logic                qual;
  logic [SAMPLE_W-1:0] level_nxt;
  logic                pressed_nxt;

  ctkd_calib #(
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) u_calib (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (cal_take),
    .sample   (in_sample),
    .emit_ack (emit_ack),
    .stat     (stat),
    .baseline (baseline),
    .lo       (lo),
    .hi       (hi)
  );

  always_comb begin
    grp_last    = (grp_cnt_r == GC_W'(SCAN_SAMPLES - 1));
    out_free    = !out_valid_r || out_ready;
    in_ready_w  = stat.calibrating || (stat.done && (!grp_last || out_free));
    take        = in_valid && in_ready_w;
    cal_take    = take && stat.calibrating;
    scan_take   = take && stat.done;
    emit_ack    = stat.pending && out_free;
    in_win      = (in_sample >= cap_low_r) && (in_sample <= cap_high_r);
    max_nxt     = (in_sample > grp_max_r) ? in_sample : grp_max_r;
    vc_nxt      = vld_cnt_r + VC_W'(in_win);
    qual        = (4'(vc_nxt) >= 4'(min_valid_r));
    level_nxt   = qual ? max_nxt : '0;
    pressed_nxt = ({1'b0, level_nxt} > lo) && ({4'b0000, level_nxt} < hi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_low_r   <= CAPTURE_LOW_RST;
      cap_high_r  <= CAPTURE_HIGH_RST;
      min_valid_r <= MIN_VALID_RST;
    end else if (cfg_we) begin
      case (ctkd_cfg_idx_t'(cfg_index))
        CFG_CAPTURE_LOW:  cap_low_r   <= cfg_wdata;
        CFG_CAPTURE_HIGH: cap_high_r  <= cfg_wdata;
        CFG_MIN_VALID:    min_valid_r <= cfg_wdata[MINV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_cnt_r <= '0;
      grp_max_r <= '0;
      vld_cnt_r <= '0;
    end else if (scan_take) begin
      if (grp_last) begin
        grp_cnt_r <= '0;
        grp_max_r <= '0;
        vld_cnt_r <= '0;
      end else begin
        grp_cnt_r <= grp_cnt_r + 1'b1;
        grp_max_r <= max_nxt;
        vld_cnt_r <= vc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_ack || (scan_take && grp_last)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ack) begin
      out_kind_r    <= KIND_CALIB;
      out_level_r   <= baseline;
      out_pressed_r <= 1'b0;
    end else if (scan_take && grp_last) begin
      out_kind_r    <= KIND_SCAN;
      out_level_r   <= level_nxt;
      out_pressed_r <= pressed_nxt;
    end
  end

  assign in_ready    = in_ready_w;
  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_level   = out_level_r;
  assign out_pressed = out_pressed_r;

  `CTKD_ASSERT_IMP(a_ready_mode, in_ready, stat.calibrating || stat.done)
  `CTKD_ASSERT_NEXT(a_emit_loads, emit_ack, out_valid && (out_kind == KIND_CALIB))
  `CTKD_ASSERT_IMP(a_scan_after_cal, out_valid && (out_kind == KIND_SCAN), stat.done)
  `CTKD_ASSERT_IMP(a_grp_range, 1'b1, grp_cnt_r <= GC_W'(SCAN_SAMPLES - 1))

endmodule
